@@ rtl/lspe_pkg.sv @@
// Shared types and constants for the line sensor position estimator.
// No dependencies; used by every module of the block.
package lspe_pkg;

   localparam int PULSE_W   = 18;   // width of one channel on the request bus
   localparam int MAX_CH    = 8;    // channels carried by one request beat
   localparam int LVL_W     = 11;   // normalized level 0..1024
   localparam int FRAC_BITS = 10;   // quotient bits of the level divide
   localparam int POS_W     = 13;   // position 0..7168
   localparam int CSR_W     = 11;

   localparam logic [LVL_W-1:0] FULL_SCALE = 11'd1024;

   localparam logic [1:0] STAT_MEASURED  = 2'd0;
   localparam logic [1:0] STAT_NOT_CAL   = 2'd1;
   localparam logic [1:0] STAT_CAL_TAKEN = 2'd2;
   localparam logic [1:0] STAT_CAL_DONE  = 2'd3;

   localparam logic CSR_ON_LINE = 1'b0;
   localparam logic CSR_NOISE   = 1'b1;

   typedef struct packed {
      logic load_first;
      logic load_val;
      logic cal_update;
      logic cal_first;
      logic cal_finish;
      logic div_start;
      logic div_step;
   } lane_ctl_type;

endpackage

@@ rtl/lspe_lane.sv @@
// One sensor channel: pair minimum, calibration tracking and a bit-serial
// normalizing divide. Depends on lspe_pkg.
module lspe_lane #(
   parameter int PULSE_BITS = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lspe_pkg::lane_ctl_type        ctl,
   input  logic [PULSE_BITS-1:0]         pulse,
   output logic [lspe_pkg::LVL_W-1:0]    level
);

   logic [PULSE_BITS-1:0] first_ff, val_ff, smin_ff, smax_ff, lo_ff, hi_ff;
   logic [PULSE_BITS-1:0] dvs_ff, rem_ff;
   logic [lspe_pkg::FRAC_BITS-1:0] quot_ff;
   logic                           sat_ff;
   logic [lspe_pkg::LVL_W-1:0]     sat_lvl_ff;

   logic [PULSE_BITS-1:0] val_in, min_in, max_in;
   logic [PULSE_BITS:0]   r2;
   logic                  ge;

   always_comb begin
      val_in = (first_ff < pulse) ? first_ff : pulse;
      min_in = (ctl.cal_first || val_ff < smin_ff) ? val_ff : smin_ff;
      max_in = (ctl.cal_first || val_ff > smax_ff) ? val_ff : smax_ff;
      r2     = {rem_ff, 1'b0};
      ge     = r2 >= {1'b0, dvs_ff};
      level  = sat_ff ? sat_lvl_ff : {1'b0, quot_ff};
   end

   always_ff @(posedge clock) begin
      if (ctl.load_first) first_ff <= pulse;
      if (ctl.load_val) val_ff <= val_in;
      if (ctl.cal_update) begin
         smin_ff <= min_in;
         smax_ff <= max_in;
      end
      if (ctl.div_start) begin
         // out-of-range and inverted calibration saturate without dividing
         if (val_ff <= lo_ff) begin
            sat_ff     <= 1'b1;
            sat_lvl_ff <= '0;
         end else if (val_ff >= hi_ff) begin
            sat_ff     <= 1'b1;
            sat_lvl_ff <= lspe_pkg::FULL_SCALE;
         end else begin
            sat_ff <= 1'b0;
         end
         rem_ff  <= val_ff - lo_ff;
         dvs_ff  <= hi_ff - lo_ff;
         quot_ff <= '0;
      end else if (ctl.div_step) begin
         rem_ff  <= ge ? PULSE_BITS'(r2 - {1'b0, dvs_ff}) : r2[PULSE_BITS-1:0];
         quot_ff <= {quot_ff[lspe_pkg::FRAC_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '1;
         hi_ff <= '0;
      end else if (ctl.cal_update && ctl.cal_finish) begin
         if (min_in > hi_ff) hi_ff <= min_in;
         if (max_in < lo_ff) lo_ff <= max_in;
      end
   end

endmodule

@@ rtl/lspe_merge.sv @@
// Merges lane levels: threshold tests, weighted sums and a bit-serial
// divide for the position. Depends on lspe_pkg.
module lspe_merge #(
   parameter int CHANNELS = 8
) (
   input  logic                                       clock,
   input  logic [CHANNELS-1:0][lspe_pkg::LVL_W-1:0]   levels,
   input  logic [lspe_pkg::CSR_W-1:0]                 on_thr,
   input  logic [lspe_pkg::CSR_W-1:0]                 noise_thr,
   input  logic                                       load,
   input  logic                                       step,
   output logic                                       online,
   output logic                                       lost,
   output logic [lspe_pkg::POS_W-1:0]                 quot
);

   localparam int SW = $clog2(CHANNELS * 1024 + 1);
   localparam int PW = lspe_pkg::POS_W;
   localparam int WW = SW + PW;

   logic          online_c;
   logic [SW-1:0] sum_c;
   logic [WW-1:0] wsum_c;
   logic [SW:0]   r2;
   logic          ge;

   logic          online_ff, lost_ff;
   logic [SW-1:0] rem_ff, dvs_ff;
   logic [PW-1:0] dvd_ff, quot_ff;

   always_comb begin
      online_c = 1'b0;
      sum_c    = '0;
      wsum_c   = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (levels[i] > on_thr) online_c = 1'b1;
         if (levels[i] > noise_thr) begin
            sum_c  = sum_c + SW'(levels[i]);
            wsum_c = wsum_c + ((WW'(i) * WW'(levels[i])) << lspe_pkg::FRAC_BITS);
         end
      end
      r2 = {rem_ff, dvd_ff[PW-1]};
      ge = r2 >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         // quotient stays below 2**PW, so the top bits already sit below the divisor
         online_ff <= online_c;
         lost_ff   <= !online_c || (sum_c == '0);
         rem_ff    <= wsum_c[WW-1:PW];
         dvd_ff    <= wsum_c[PW-1:0];
         dvs_ff    <= sum_c;
         quot_ff   <= '0;
      end else if (step) begin
         rem_ff  <= ge ? SW'(r2 - {1'b0, dvs_ff}) : r2[SW-1:0];
         dvd_ff  <= {dvd_ff[PW-2:0], 1'b0};
         quot_ff <= {quot_ff[PW-2:0], ge};
      end
   end

   assign online = online_ff;
   assign lost   = lost_ff;
   assign quot   = quot_ff;

endmodule

@@ rtl/line_sensor_position_estimator_unit.sv @@
// Top level of the line sensor position estimator: sequencer, config
// registers and result register. Depends on lspe_pkg, lspe_lane, lspe_merge.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata 8 x 18b pulses, tuser op
//  rsp     | out       | rsp_tvalid/tready    | tdata position, on_line; tuser status
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
// A first read of a pair is only latched, a measure pair before calibration goes
// straight to the result, and a calibration pair passes through the calibration
// update. A measure pair steps through accept, divide start, the per-lane level
// divide, the merge state, the position divide, a state that takes the quotient
// and one that hands it to the result register; a lost line skips the position
// divide. One item is in flight at a time; the result register lets the next
// item enter while a result waits. A stalled rsp holds the sequencer in its
// last state. Reset clears control and calibration state.
module line_sensor_position_estimator_unit #(
   parameter int CHANNELS    = 8,
   parameter int CAL_SAMPLES = 10,
   parameter int PULSE_BITS  = 18
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // pulse_ch0 [17:0] .. pulse_ch7 [143:126]
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // position [12:0], on_line [13], zero fill
   output logic [1:0]   rsp_tuser,   // status
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [10:0]  csr_wdata
);

   localparam int PW = lspe_pkg::POS_W;
   localparam logic [PW-1:0] EDGE_HI = PW'((CHANNELS - 1) * 1024);
   localparam logic [PW-1:0] EDGE_MID = PW'((CHANNELS - 1) * 512);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CAL   = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_NORM  = 3'd3;
   localparam logic [2:0] S_MERGE = 3'd4;
   localparam logic [2:0] S_POS   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [3:0]  count_ff, count_in;
   logic        pend_ff, pend_in;
   logic        cal_ff, cal_in;
   logic [PW-1:0] last_ff, last_in;
   logic        online_ff, online_in;
   logic [1:0]  status_ff, status_in;
   logic [10:0] on_thr_ff, noise_thr_ff;
   logic        rvalid_ff, rvalid_in;
   logic [PW-1:0] rpos_ff;
   logic        ronline_ff;
   logic [1:0]  rstatus_ff;

   logic                    accept, deliver;
   logic [4:0]              count_next;
   lspe_pkg::lane_ctl_type  ctl;
   logic [CHANNELS-1:0][lspe_pkg::LVL_W-1:0] levels;
   logic                    m_load, m_step, m_online, m_lost;
   logic [PW-1:0]           m_quot;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign deliver    = (state_ff == S_DONE) && (!rvalid_ff || rsp_tready);
   assign count_next = {1'b0, count_ff} + 5'd1;

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      lspe_lane #(.PULSE_BITS(PULSE_BITS)) u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .pulse (PULSE_BITS'(req_tdata[g*lspe_pkg::PULSE_W +: lspe_pkg::PULSE_W])),
         .level (levels[g])
      );
   end

   lspe_merge #(.CHANNELS(CHANNELS)) u_merge (
      .clock     (clock),
      .levels    (levels),
      .on_thr    (on_thr_ff),
      .noise_thr (noise_thr_ff),
      .load      (m_load),
      .step      (m_step),
      .online    (m_online),
      .lost      (m_lost),
      .quot      (m_quot)
   );

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      cal_in    = cal_ff;
      last_in   = last_ff;
      online_in = online_ff;
      status_in = status_ff;
      ctl       = '0;
      m_load    = 1'b0;
      m_step    = 1'b0;
      ctl.cal_first  = (count_ff == 4'd0);
      ctl.cal_finish = (count_next >= 5'(CAL_SAMPLES));
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!pend_ff) begin
                  ctl.load_first = 1'b1;
                  pend_in        = 1'b1;
               end else begin
                  ctl.load_val = 1'b1;
                  pend_in      = 1'b0;
                  online_in    = 1'b0;
                  if (req_tuser) begin
                     state_in = S_CAL;
                  end else if (!cal_ff) begin
                     status_in = lspe_pkg::STAT_NOT_CAL;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_START;
                  end
               end
            end
         end
         S_CAL: begin
            ctl.cal_update = 1'b1;
            if (ctl.cal_finish) begin
               count_in  = 4'd0;
               cal_in    = 1'b1;
               status_in = lspe_pkg::STAT_CAL_DONE;
            end else begin
               count_in  = count_next[3:0];
               status_in = lspe_pkg::STAT_CAL_TAKEN;
            end
            state_in = S_DONE;
         end
         S_START: begin
            ctl.div_start = 1'b1;
            step_in       = 4'd0;
            state_in      = S_NORM;
         end
         S_NORM: begin
            ctl.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == 4'(lspe_pkg::FRAC_BITS - 1)) state_in = S_MERGE;
         end
         S_MERGE: begin
            m_load   = 1'b1;
            step_in  = 4'd0;
            state_in = S_POS;
         end
         S_POS: begin
            online_in = m_online;
            status_in = lspe_pkg::STAT_MEASURED;
            if (m_lost) begin
               // park at the nearer edge
               last_in  = (last_ff < EDGE_MID) ? '0 : EDGE_HI;
               state_in = S_DONE;
            end else begin
               m_step  = 1'b1;
               step_in = step_ff + 4'd1;
               if (step_ff == 4'(PW - 1)) state_in = S_FIN;
            end
         end
         S_FIN: begin
            last_in  = m_quot;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (deliver) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      if (deliver) rvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         cal_ff       <= 1'b0;
         last_ff      <= '0;
         online_ff    <= 1'b0;
         status_ff    <= lspe_pkg::STAT_MEASURED;
         rvalid_ff    <= 1'b0;
         on_thr_ff    <= 11'd900;
         noise_thr_ff <= 11'd500;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         cal_ff    <= cal_in;
         last_ff   <= last_in;
         online_ff <= online_in;
         status_ff <= status_in;
         rvalid_ff <= rvalid_in;
         if (csr_we) begin
            case (csr_index)
               lspe_pkg::CSR_ON_LINE: on_thr_ff    <= csr_wdata;
               lspe_pkg::CSR_NOISE:   noise_thr_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rpos_ff    <= last_ff;
         ronline_ff <= online_ff;
         rstatus_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {2'b00, ronline_ff, rpos_ff};
   assign rsp_tuser  = rstatus_ff;

   a_online_only_measured: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != lspe_pkg::STAT_MEASURED |-> !rsp_tdata[13])
      else $error("on_line set on a result that is not a measurement");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PW-1:0] <= EDGE_HI)
      else $error("position beyond the last sensor");

   a_cal_done_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == lspe_pkg::STAT_CAL_DONE |-> cal_ff)
      else $error("calibration finished without the calibrated flag");

   a_pair_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !pend_ff)
      else $error("pair still open while a pair is being processed");

endmodule

@@ tb/lspe_checker.sv @@
// Checker for the line sensor position estimator: watches req, rsp and csr,
// predicts each result from its own copy of the block state and compares.
// Depends on lspe_pkg.
module lspe_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [10:0]  csr_wdata,
   output int           mismatch_count,
   output int           results_owed
);

   localparam int NCH      = 8;
   localparam int NSAMPLES = 10;
   localparam int POS_W    = lspe_pkg::POS_W;
   localparam int PULSE_W  = lspe_pkg::PULSE_W;
   localparam int LVL_W    = lspe_pkg::LVL_W;
   localparam int CSR_W    = lspe_pkg::CSR_W;
   localparam logic [POS_W-1:0] EDGE_POS = POS_W'((NCH - 1) * 1024);
   localparam logic [POS_W-1:0] MID_POS  = POS_W'((NCH - 1) * 512);

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             on_line;
      logic [1:0]       status;
   } line_result_type;

   line_result_type owed_results[$];

   logic [CSR_W-1:0]   on_line_level;
   logic [CSR_W-1:0]   noise_level;
   logic               half_pair;
   logic [PULSE_W-1:0] held_read  [NCH];
   logic [PULSE_W-1:0] sess_lo    [NCH];
   logic [PULSE_W-1:0] sess_hi    [NCH];
   logic [3:0]         sessions;
   logic [PULSE_W-1:0] dark_ref   [NCH];
   logic [PULSE_W-1:0] bright_ref [NCH];
   logic               calibrated;
   logic [POS_W-1:0]   held_position;

   initial begin
      mismatch_count = 0;
      results_owed = 0;
   end

   function automatic logic [LVL_W-1:0] level_of(logic [PULSE_W-1:0] v,
                                                 logic [PULSE_W-1:0] lo,
                                                 logic [PULSE_W-1:0] hi);
      longint unsigned num;
      if (v <= lo) return '0;
      if (v >= hi) return lspe_pkg::FULL_SCALE;
      num = longint'(v - lo) << lspe_pkg::FRAC_BITS;
      return LVL_W'(num / longint'(hi - lo));
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, want %0d at t=%0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Fold one accepted beat into the model; queue a result on the second read.
   task automatic predict_beat(logic [143:0] data, logic op);
      logic [PULSE_W-1:0] v [NCH];
      logic [PULSE_W-1:0] b;
      logic [LVL_W-1:0]   lvl;
      longint unsigned    wsum, sum;
      line_result_type    r;
      r = '0;
      wsum = 0;
      sum = 0;
      if (!half_pair) begin
         for (int i = 0; i < NCH; i++) held_read[i] = data[PULSE_W*i +: PULSE_W];
         half_pair = 1'b1;
         return;
      end
      half_pair = 1'b0;
      for (int i = 0; i < NCH; i++) begin
         b = data[PULSE_W*i +: PULSE_W];
         v[i] = (held_read[i] < b) ? held_read[i] : b;
      end
      if (op) begin
         for (int i = 0; i < NCH; i++) begin
            if (sessions == 0) begin
               sess_lo[i] = v[i];
               sess_hi[i] = v[i];
            end else begin
               if (v[i] < sess_lo[i]) sess_lo[i] = v[i];
               if (v[i] > sess_hi[i]) sess_hi[i] = v[i];
            end
         end
         sessions = sessions + 4'd1;
         if (sessions >= NSAMPLES) begin
            for (int i = 0; i < NCH; i++) begin
               if (sess_lo[i] > bright_ref[i]) bright_ref[i] = sess_lo[i];
               if (sess_hi[i] < dark_ref[i]) dark_ref[i] = sess_hi[i];
            end
            calibrated = 1'b1;
            sessions = '0;
            r.status = lspe_pkg::STAT_CAL_DONE;
         end else begin
            r.status = lspe_pkg::STAT_CAL_TAKEN;
         end
      end else if (!calibrated) begin
         r.status = lspe_pkg::STAT_NOT_CAL;
      end else begin
         for (int i = 0; i < NCH; i++) begin
            lvl = level_of(v[i], dark_ref[i], bright_ref[i]);
            if (lvl > on_line_level) r.on_line = 1'b1;
            if (lvl > noise_level) begin
               wsum += longint'(i) * longint'(lvl) << 10;
               sum += lvl;
            end
         end
         // lost line: park at the nearer edge
         if (!r.on_line || sum == 0)
            held_position = (held_position < MID_POS) ? '0 : EDGE_POS;
         else
            held_position = POS_W'(wsum / sum);
         r.status = lspe_pkg::STAT_MEASURED;
      end
      r.position = held_position;
      owed_results.push_back(r);
   endtask

   always @(posedge clock) begin
      line_result_type want;
      if (reset) begin
         on_line_level = 11'd900;
         noise_level = 11'd500;
         half_pair = 1'b0;
         sessions = '0;
         calibrated = 1'b0;
         held_position = '0;
         for (int i = 0; i < NCH; i++) begin
            dark_ref[i] = '1;
            bright_ref[i] = '0;
         end
         owed_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == lspe_pkg::CSR_ON_LINE) on_line_level = csr_wdata;
            else noise_level = csr_wdata;
         end
         if (req_tvalid && req_tready) predict_beat(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result, position", rsp_tdata[12:0], -1);
            end else begin
               want = owed_results.pop_front();
               if (rsp_tdata[12:0] != want.position)
                  report_mismatch("position", rsp_tdata[12:0], want.position);
               if (rsp_tdata[13] != want.on_line)
                  report_mismatch("on_line", rsp_tdata[13], want.on_line);
               if (rsp_tdata[15:14] != 2'b00)
                  report_mismatch("tdata fill", rsp_tdata[15:14], 0);
               if (rsp_tuser != want.status)
                  report_mismatch("status", rsp_tuser, want.status);
            end
         end
      end
      results_owed = owed_results.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the line sensor position estimator testbench: clock, reset,
// stimulus and verdict. Depends on lspe_pkg, lspe_checker and the block.
module testbench;

   localparam int LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_index = lspe_pkg::CSR_ON_LINE;
   logic [10:0]  csr_wdata = '0;
   int           mismatch_count;
   int           results_owed;
   int           cycles = 0;
   bit           no_idle = 1'b0;

   line_sensor_position_estimator_unit dut (.*);

   lspe_checker u_checker (.*);

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   // Reflectance pattern: bright (long) under the line near center, dark elsewhere.
   function automatic logic [143:0] line_read(int center, bit lost);
      logic [143:0] d;
      int span;
      d = '0;
      for (int i = 0; i < 8; i++) begin
         span = (i > center) ? i - center : center - i;
         if (lost || span > 1)
            d[18*i +: 18] = ($urandom_range(0, 15) == 0) ? 18'h3FFFF
                                                          : 18'(100 + $urandom_range(0, 400));
         else if (span == 0)
            d[18*i +: 18] = 18'(20000 + $urandom_range(0, 20000));
         else
            d[18*i +: 18] = 18'(3000 + $urandom_range(0, 8000));
      end
      return d;
   endfunction

   function automatic logic [143:0] noise_read();
      logic [143:0] d;
      for (int i = 0; i < 8; i++)
         case ($urandom_range(0, 5))
            0: d[18*i +: 18] = '0;
            1: d[18*i +: 18] = '1;
            default: d[18*i +: 18] = 18'($urandom);
         endcase
      return d;
   endfunction

   task automatic send_beat(logic op, logic [143:0] data);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_pair(logic op, logic [143:0] a, logic [143:0] b);
      send_beat(logic'($urandom_range(0, 1)), a);
      send_beat(op, b);
   endtask

   task automatic calibrate_session();
      for (int k = 0; k < 10; k++)
         send_pair(1'b1, line_read(k % 8, k == 9), line_read(k % 8, k == 9));
   endtask

   // Drain every owed result, then let the block go quiet before csr writes.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_thresholds(logic [10:0] on_line, logic [10:0] noise);
      csr_we <= 1'b1;
      csr_index <= lspe_pkg::CSR_ON_LINE;
      csr_wdata <= on_line;
      @(posedge clock);
      csr_index <= lspe_pkg::CSR_NOISE;
      csr_wdata <= noise;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int s;
      forever begin
         s = draw_gap();
         if (s > 0) begin
            rsp_tready <= 1'b0;
            repeat (s) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      logic [10:0] on_set [6];
      logic [10:0] noise_set [6];
      int          items;
      int          pick;
      on_set = '{11'd900, 11'd0, 11'd1024, 11'd2047, 11'd1024, 11'd700};
      noise_set = '{11'd500, 11'd0, 11'd1024, 11'd2047, 11'd0, 11'd300};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: measure before calibration, one session, then edge cases
      send_pair(1'b0, '0, '1);
      calibrate_session();
      send_pair(1'b0, line_read(0, 0), line_read(0, 0));
      send_pair(1'b0, line_read(7, 0), line_read(7, 0));
      send_pair(1'b0, line_read(3, 1), line_read(3, 1));
      send_pair(1'b0, '1, '1);
      send_pair(1'b0, '0, '0);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         if (ph == 5) write_thresholds(11'($urandom_range(0, 1024)),
                                       11'($urandom_range(0, 1024)));
         else write_thresholds(on_set[ph], noise_set[ph]);
         items = 0;
         while (items < 140) begin
            if (items % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
               calibrate_session();
               items += 20;
            end else if (pick < 17) begin
               s_pair_measure: begin
                  int c;
                  bit lost;
                  c = $urandom_range(0, 7);
                  lost = ($urandom_range(0, 5) == 0);
                  send_pair(1'b0, line_read(c, lost), line_read(c, lost));
               end
               items += 2;
            end else begin
               send_beat(logic'($urandom_range(0, 1)), noise_read());
               items += 1;
            end
         end
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
